[rtl/core/pair_nonbonded_energy_accumulator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pair non-bonded energy accumulator.
// ----------------------------------------------------------------------------
`ifndef PAIR_NONBONDED_ENERGY_ACCUMULATOR_CORE_ASSERT_SVH
`define PAIR_NONBONDED_ENERGY_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define PNEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication from a trigger to a consequence in the next cycle.
`define PNEA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`else
`define PNEA_ASSERT(lbl, prop, msg)
`define PNEA_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

[rtl/core/pnea_pkg.sv]
// ----------------------------------------------------------------------------
// pnea_pkg
// Types, constants and arithmetic helpers of the pair energy accumulator.
// ----------------------------------------------------------------------------
package pnea_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned ExpW    = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCoulombCutoff = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgVdwCutoff     = CfgIdxW'(1);

  localparam logic [31:0] CutoffReset = 32'hFFFF_0000;
  localparam logic [63:0] PosMax      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMax      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] coulomb_coef;
    logic signed [31:0] dispersion_coef;
    logic signed [31:0] repulsion_coef;
    logic               last_pair;
  } pnea_in_t;

  typedef struct packed {
    logic signed [63:0] total_energy;
    logic               saturated;
  } pnea_out_t;

  // One classified pair handed from the front to the back.
  typedef struct packed {
    logic [63:0]        dist_sq;
    logic               use_c;
    logic               use_v;
    logic signed [31:0] cq;
    logic signed [31:0] c6;
    logic signed [31:0] c12;
    logic               last;
  } pnea_work_t;

  // Saturating signed add; bit 64 flags saturation.
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return {1'b1, (a[63] ? NegMax : PosMax)};
    end
    return {1'b0, s};
  endfunction

  // Saturating signed subtract; bit 64 flags saturation.
  function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      return {1'b1, (a[63] ? NegMax : PosMax)};
    end
    return {1'b0, s};
  endfunction

  // Term at zero distance: bound of the coefficient's sign.
  function automatic logic [63:0] zero_term(input logic signed [31:0] c);
    if (c > 0) return PosMax;
    if (c < 0) return NegMax;
    return 64'd0;
  endfunction

  // Magnitude product shifted by sh into Q32.32; bit 64 flags saturation.
  function automatic logic [64:0] scale_term(input logic [63:0] p,
                                             input logic signed [ExpW-1:0] sh,
                                             input logic neg);
    logic [63:0]     lim;
    logic [63:0]     r;
    logic            flag;
    logic [ExpW-1:0] amt;
    lim  = neg ? NegMax : PosMax;
    flag = 1'b0;
    amt  = sh[ExpW-1] ? (~sh + 1'b1) : sh;
    if (p == 64'd0) begin
      r = 64'd0;
    end else if (!sh[ExpW-1]) begin
      if (sh >= ExpW'(63) || p > (lim >> amt)) begin
        flag = 1'b1;
        r    = lim;
      end else begin
        r = p << amt;
      end
    end else begin
      r = p >> amt;
    end
    return {flag, (neg ? (64'd0 - r) : r)};
  endfunction

endpackage

[rtl/core/pnea_front.sv]
// ----------------------------------------------------------------------------
// pnea_front
// Holds the cutoff registers, takes pair items, forms the squared distance
// and classifies each pair against the cutoffs.
// ----------------------------------------------------------------------------
module pnea_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pnea_pkg::pnea_in_t             in_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pnea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output pnea_pkg::pnea_work_t           push_data_o
);
  import pnea_pkg::*;

  logic [31:0] cut_c_q, cut_v_q;
  logic [61:0] cut_c_sq_q, cut_v_sq_q;
  logic        s1_valid_q;
  logic [63:0] sqx_q, sqy_q, sqz_q;
  logic signed [31:0] cq_q, c6_q, c12_q;
  logic        last_q;
  logic        in_acc;
  logic [64:0] sum_xy, sum_xyz;
  logic [63:0] d_xy, d_all;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid_q || push_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Absolute coordinate difference squared.
  function automatic logic [63:0] sq_diff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [31:0]        m;
    d = 33'(a) - 33'(b);
    m = d[32] ? 32'(-d) : d[31:0];
    return m * m;
  endfunction

  // Cutoff registers and their squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_c_q    <= CutoffReset;
      cut_v_q    <= CutoffReset;
      cut_c_sq_q <= '0;
      cut_v_sq_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgCoulombCutoff: cut_c_q <= cfg_data_i;
          CfgVdwCutoff:     cut_v_q <= cfg_data_i;
          default:          ;
        endcase
      end
      cut_c_sq_q <= cut_c_q[30:0] * cut_c_q[30:0];
      cut_v_sq_q <= cut_v_q[30:0] * cut_v_q[30:0];
    end
  end

  // Square stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sqx_q  <= sq_diff(in_data_i.pos_a_x, in_data_i.pos_b_x);
      sqy_q  <= sq_diff(in_data_i.pos_a_y, in_data_i.pos_b_y);
      sqz_q  <= sq_diff(in_data_i.pos_a_z, in_data_i.pos_b_z);
      cq_q   <= in_data_i.coulomb_coef;
      c6_q   <= in_data_i.dispersion_coef;
      c12_q  <= in_data_i.repulsion_coef;
      last_q <= in_data_i.last_pair;
    end
  end

  // Clamped distance sum and cutoff classification.
  always_comb begin
    sum_xy  = {1'b0, sqx_q} + {1'b0, sqy_q};
    d_xy    = sum_xy[64] ? '1 : sum_xy[63:0];
    sum_xyz = {1'b0, d_xy} + {1'b0, sqz_q};
    d_all   = sum_xyz[64] ? '1 : sum_xyz[63:0];
    push_data_o.dist_sq = d_all;
    push_data_o.use_c   = cut_c_q[31] || (d_all <= {2'b00, cut_c_sq_q});
    push_data_o.use_v   = cut_v_q[31] || (d_all <= {2'b00, cut_v_sq_q});
    push_data_o.cq      = cq_q;
    push_data_o.c6      = c6_q;
    push_data_o.c12     = c12_q;
    push_data_o.last    = last_q;
  end

  assign push_valid_o = s1_valid_q;

endmodule

[rtl/core/pnea_queue.sv]
// ----------------------------------------------------------------------------
// pnea_queue
// Short queue of classified pairs between the front and the back.
// ----------------------------------------------------------------------------
`include "pair_nonbonded_energy_accumulator_core_assert.svh"

module pnea_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  pnea_pkg::pnea_work_t  push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output pnea_pkg::pnea_work_t  pop_data_o
);
  import pnea_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  pnea_work_t          mem_q [QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  `PNEA_ASSERT(a_cnt_bound, cnt_q <= (PtrW+1)'(QDepth), "queue count beyond depth")
  `PNEA_ASSERT_NEXT(a_fill, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "fill count lost a push")
  `PNEA_ASSERT_NEXT(a_drain, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "fill count lost a pop")

endmodule

[rtl/core/pnea_back.sv]
// ----------------------------------------------------------------------------
// pnea_back
// Evaluates the inverse distance powers of one pair, forms the Coulomb,
// dispersion and repulsion terms and keeps the saturating sums.
// ----------------------------------------------------------------------------
`include "pair_nonbonded_energy_accumulator_core_assert.svh"

module pnea_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  pnea_pkg::pnea_work_t  pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pnea_pkg::pnea_out_t   out_data_o
);
  import pnea_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ZERO, ST_NORM, ST_SQRT, ST_DIV,
    ST_MC, ST_TC, ST_M2, ST_N2, ST_M4, ST_N4, ST_M6, ST_N6,
    ST_MD, ST_TD, ST_M12, ST_N12, ST_MR, ST_TR, ST_FIN, ST_EMIT
  } state_e;

  state_e              state_q;
  pnea_work_t          w_q;
  logic [63:0]         n_q, res_q, bit_q;
  logic [5:0]          k_q, cnt_q;
  logic [32:0]         rem_q;
  logic [31:0]         s_q, m1_q, m2_q, my_q;
  logic signed [ExpW-1:0] e1_q, e2_q, ey_q;
  logic [63:0]         p_q;
  logic [63:0]         csum_q, dsum_q, rsum_q, tot_q;
  logic                sat_q, out_valid_q;
  pnea_out_t           out_q;

  logic [31:0]         mul_a, mul_b;
  logic [64:0]         rb;
  logic [32:0]         r2;
  logic [31:0]         pm;
  logic signed [ExpW-1:0] pe;
  logic [31:0]         mag_c, mag_6, mag_12;
  logic [64:0]         tc, td, tr, ac, ad, ar;
  logic [64:0]         zc, zd, zr, fs, fa;

  assign pop_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Coefficient magnitudes.
  assign mag_c  = w_q.cq[31]  ? 32'(-w_q.cq)  : w_q.cq;
  assign mag_6  = w_q.c6[31]  ? 32'(-w_q.c6)  : w_q.c6;
  assign mag_12 = w_q.c12[31] ? 32'(-w_q.c12) : w_q.c12;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      ST_MC:   begin mul_a = mag_c;  mul_b = m1_q; end
      ST_M2:   begin mul_a = m1_q;   mul_b = m1_q; end
      ST_M4:   begin mul_a = m2_q;   mul_b = m2_q; end
      ST_M6:   begin mul_a = my_q;   mul_b = m2_q; end
      ST_MD:   begin mul_a = mag_6;  mul_b = my_q; end
      ST_M12:  begin mul_a = my_q;   mul_b = my_q; end
      ST_MR:   begin mul_a = mag_12; mul_b = my_q; end
      default: begin mul_a = m1_q;   mul_b = m1_q; end
    endcase
  end

  // Square root step, divider step and product renormalization.
  always_comb begin
    rb = {1'b0, res_q} + {1'b0, bit_q};
    r2 = {rem_q[31:0], 1'b1};
    pm = p_q[63] ? p_q[63:32] : p_q[62:31];
    pe = p_q[63] ? ExpW'(32) : ExpW'(31);
  end

  // Terms and sums.
  always_comb begin
    tc = scale_term(p_q, e1_q + ExpW'(16), w_q.cq[31]);
    td = scale_term(p_q, ey_q + ExpW'(16), w_q.c6[31]);
    tr = scale_term(p_q, ey_q + ExpW'(16), w_q.c12[31]);
    ac = sat_add(csum_q, tc[63:0]);
    ad = sat_add(dsum_q, td[63:0]);
    ar = sat_add(rsum_q, tr[63:0]);
    zc = sat_add(csum_q, zero_term(w_q.cq));
    zd = sat_add(dsum_q, zero_term(w_q.c6));
    zr = sat_add(rsum_q, zero_term(w_q.c12));
    fs = sat_sub(csum_q, dsum_q);
    fa = sat_add(tot_q, rsum_q);
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Sequencer for one pair and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      csum_q      <= '0;
      dsum_q      <= '0;
      rsum_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      w_q         <= '0;
      n_q <= '0; res_q <= '0; bit_q <= '0; k_q <= '0; cnt_q <= '0;
      rem_q <= '0; s_q <= '0; m1_q <= '0; m2_q <= '0; my_q <= '0;
      e1_q <= '0; e2_q <= '0; ey_q <= '0; tot_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            w_q <= pop_data_i;
            n_q <= pop_data_i.dist_sq;
            k_q <= '0;
            if (pop_data_i.dist_sq == 64'd0) state_q <= ST_ZERO;
            else if (pop_data_i.use_c || pop_data_i.use_v) state_q <= ST_NORM;
            else state_q <= ST_FIN;
          end
        end
        ST_ZERO: begin
          sat_q <= 1'b1;
          if (w_q.use_c) csum_q <= zc[63:0];
          if (w_q.use_v) begin
            dsum_q <= zd[63:0];
            rsum_q <= zr[63:0];
          end
          state_q <= ST_FIN;
        end
        ST_NORM: begin
          if (n_q[63:62] != 2'b00) begin
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end else begin
            n_q <= n_q << 2;
            k_q <= k_q + 6'd2;
          end
        end
        ST_SQRT: begin
          if (n_q >= rb[63:0]) begin
            n_q   <= n_q - rb[63:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == 6'd31) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd0) s_q <= res_q[31:0];
          if (cnt_q != 6'd0 && r2 >= {1'b0, s_q}) begin
            rem_q <= r2 - {1'b0, s_q};
            m1_q  <= {m1_q[30:0], 1'b1};
          end else if (cnt_q != 6'd0) begin
            rem_q <= r2;
            m1_q  <= {m1_q[30:0], 1'b0};
          end else begin
            m1_q <= '0;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) begin
            e1_q    <= ExpW'(k_q[5:1]) - ExpW'(47);
            state_q <= w_q.use_c ? ST_MC : ST_M2;
          end
        end
        ST_MC: state_q <= ST_TC;
        ST_TC: begin
          csum_q  <= ac[63:0];
          sat_q   <= sat_q | tc[64] | ac[64];
          state_q <= w_q.use_v ? ST_M2 : ST_FIN;
        end
        ST_M2: state_q <= ST_N2;
        ST_N2: begin
          m2_q    <= pm;
          e2_q    <= e1_q + e1_q + pe;
          state_q <= ST_M4;
        end
        ST_M4: state_q <= ST_N4;
        ST_N4: begin
          my_q    <= pm;
          ey_q    <= e2_q + e2_q + pe;
          state_q <= ST_M6;
        end
        ST_M6: state_q <= ST_N6;
        ST_N6: begin
          my_q    <= pm;
          ey_q    <= ey_q + e2_q + pe;
          state_q <= ST_MD;
        end
        ST_MD: state_q <= ST_TD;
        ST_TD: begin
          dsum_q  <= ad[63:0];
          sat_q   <= sat_q | td[64] | ad[64];
          state_q <= ST_M12;
        end
        ST_M12: state_q <= ST_N12;
        ST_N12: begin
          my_q    <= pm;
          ey_q    <= ey_q + ey_q + pe;
          state_q <= ST_MR;
        end
        ST_MR: state_q <= ST_TR;
        ST_TR: begin
          rsum_q  <= ar[63:0];
          sat_q   <= sat_q | tr[64] | ar[64];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (w_q.last) begin
            tot_q   <= fs[63:0];
            sat_q   <= sat_q | fs[64];
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q        <= 1'b1;
            out_q.total_energy <= fa[63:0];
            out_q.saturated    <= sat_q | fa[64];
            csum_q  <= '0;
            dsum_q  <= '0;
            rsum_q  <= '0;
            sat_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PNEA_ASSERT(a_norm_nonzero, state_q != ST_NORM || n_q != 64'd0, "normalizing a zero distance")
  `PNEA_ASSERT(a_root_range, !(state_q == ST_DIV && cnt_q != 6'd0) || s_q[31],
               "square root outside its normalized range")
  `PNEA_ASSERT(a_inv_range, !(state_q == ST_MC || state_q == ST_M2) || m1_q[31],
               "inverse distance mantissa not normalized")
  `PNEA_ASSERT_NEXT(a_emit, state_q == ST_EMIT && (!out_valid_q || out_ready_i),
                    out_valid_q && csum_q == 64'd0 && !sat_q, "result emitted without clearing")

endmodule

[rtl/core/pair_nonbonded_energy_accumulator_core.sv]
// ----------------------------------------------------------------------------
// pair_nonbonded_energy_accumulator_core
// Sums Coulomb and Lennard-Jones pair energies over a stream of atom pairs
// and emits the total, saturated to signed Q32.32, on the last pair of a set.
//
// The front takes one pair per cycle, while the queue has room, into a
// single-stage distance register, classifies it against the cutoffs and
// hands it to a two-entry queue. The back evaluates one pair at a time and
// takes no new pair until it is done with the last. A pair inside a cutoff
// goes through up to 31 normalizing steps, a 32-step bit-serial square root,
// a 64-step bit-serial divider and up to 14 steps on one shared 32x32
// multiplier; a pair outside both cutoffs or at zero distance skips them.
// The last pair passes an emit state that forms the result and waits while
// an earlier result is unaccepted. A cutoff write reaches the cutoff register,
// then its registered square; write them only while the block holds no pair.
// ----------------------------------------------------------------------------
module pair_nonbonded_energy_accumulator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pnea_pkg::pnea_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pnea_pkg::pnea_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pnea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import pnea_pkg::*;

  logic       f_valid, f_ready, b_valid, b_ready;
  pnea_work_t f_data, b_data;

  pnea_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_data_o  (f_data)
  );

  pnea_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  pnea_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .pop_data_i  (b_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
